FILE: rtl/core/ctci_pkg.sv
// Shared constants, command codes and interface types of the cost table coverage block.
`default_nettype none

package ctci_pkg;

  // Table geometry
  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned COST_BITS = 32;
  localparam int unsigned IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);

  // Port field widths
  localparam int unsigned CMD_BITS       = 2;
  localparam int unsigned IN_WORD_BITS   = 32;
  localparam int unsigned OUT_INDEX_BITS = 10;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd2;

  // Request from the port side into the engine
  typedef struct packed {
    logic                    valid;
    logic [CMD_BITS-1:0]     cmd;
    logic [IN_WORD_BITS-1:0] cost;
    logic [IN_WORD_BITS-1:0] level;
  } eng_req_t;

  // Result from the engine toward the output register
  typedef struct packed {
    logic                      valid;
    logic [OUT_INDEX_BITS-1:0] index;
    logic                      covered;
    logic                      empty;
  } eng_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/ctci_engine.sv
// Prefix-maximum store with append, clear and binary-search query sequencing.
`default_nettype none

module ctci_engine (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ctci_pkg::eng_req_t  req_i,
  output logic                ready_o,
  output ctci_pkg::eng_res_t  res_o,
  input  wire                 res_ready_i
);
  import ctci_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  localparam int unsigned CMP_BITS = 64;

  logic [COST_BITS-1:0] mem [DEPTH];
  logic [COST_BITS-1:0] rd_data_q;
  logic                 rd_en;
  logic [IDX_BITS-1:0]  rd_addr;
  logic                 wr_en;
  logic [IDX_BITS-1:0]  wr_addr;
  logic [COST_BITS-1:0] wr_data;

  logic [1:0]              state_q, state_d;
  logic [CNT_BITS-1:0]     count_q, count_d;
  logic [COST_BITS-1:0]    peak_q, peak_d;
  logic [CNT_BITS-1:0]     lo_q, lo_d;
  logic [CNT_BITS-1:0]     hi_q, hi_d;
  logic [CNT_BITS-1:0]     mid_q, mid_d;
  logic [IN_WORD_BITS-1:0] level_q, level_d;
  logic [CNT_BITS-1:0]     res_n_q, res_n_d;
  logic                    res_empty_q, res_empty_d;

  logic                    accept;
  logic [COST_BITS-1:0]    cost_in;
  logic                    probe_le;
  logic [CNT_BITS-1:0]     next_lo;
  logic [CNT_BITS-1:0]     next_hi;
  logic [CNT_BITS-1:0]     span;
  logic [CNT_BITS-1:0]     n_minus_one;

  assign ready_o = (state_q == ST_IDLE);
  assign accept  = req_i.valid && ready_o;
  assign cost_in = req_i.cost[COST_BITS-1:0];

  // Compare the probed running maximum against the level
  assign probe_le = (CMP_BITS'(rd_data_q) <= CMP_BITS'(level_q));
  assign next_lo  = probe_le ? CNT_BITS'(mid_q + 1'b1) : lo_q;
  assign next_hi  = probe_le ? hi_q : mid_q;
  assign span     = next_hi - next_lo;

  // Sequence appends, clears and the search
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    peak_d      = peak_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    level_d     = level_q;
    res_n_d     = res_n_q;
    res_empty_d = res_empty_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = count_q[IDX_BITS-1:0];
    wr_data     = peak_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.cmd)
            CMD_CLEAR: begin
              count_d = '0;
              peak_d  = '0;
            end
            CMD_APPEND: begin
              if (count_q < CNT_BITS'(DEPTH)) begin
                peak_d  = (cost_in > peak_q) ? cost_in : peak_q;
                wr_en   = 1'b1;
                wr_data = peak_d;
                count_d = count_q + 1'b1;
              end
            end
            CMD_QUERY: begin
              level_d = req_i.level;
              if (count_q == '0) begin
                res_n_d     = '0;
                res_empty_d = 1'b1;
                state_d     = ST_RESULT;
              end else begin
                lo_d        = '0;
                hi_d        = count_q;
                mid_d       = count_q >> 1;
                res_empty_d = 1'b0;
                rd_en       = 1'b1;
                state_d     = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        lo_d = next_lo;
        hi_d = next_hi;
        if (next_lo < next_hi) begin
          mid_d = next_lo + (span >> 1);
          rd_en = 1'b1;
        end else begin
          res_n_d = next_lo;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = mid_d[IDX_BITS-1:0];

  // Hold the running maxima; the read is registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      peak_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      peak_q  <= peak_d;
    end
  end

  // Search and result payload
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    level_q     <= level_d;
    res_n_q     <= res_n_d;
    res_empty_q <= res_empty_d;
  end

  // Drive the result: index is one below the covered count
  assign n_minus_one   = res_n_q - 1'b1;
  assign res_o.valid   = (state_q == ST_RESULT);
  assign res_o.covered = (res_n_q != '0);
  assign res_o.empty   = res_empty_q;
  assign res_o.index   = res_o.covered ? OUT_INDEX_BITS'(n_minus_one) : '0;

endmodule

`default_nettype wire

FILE: rtl/core/cost_table_coverage_inverse.sv
// Top level of the cost table coverage block: handshakes and output register.
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ----------------------------------------------
//  in       in   in_valid_i/in_ready_o  cmd_i, cost_value_i, query_level_i
//  out      out  out_valid_o/out_ready_i covered_index_o, any_covered_o, table_empty_o
//
// Clear and append complete without leaving the idle state. A query makes one probe
// per cycle on the single read port of the prefix-maximum store. Reset clears the
// entry count and peak; the store needs no clearing pass. A result waits in the output
// register while the next transaction is accepted; a second result stalls the engine.
`default_nettype none

module cost_table_coverage_inverse (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  [ctci_pkg::CMD_BITS-1:0]        cmd_i,
  input  wire  [ctci_pkg::IN_WORD_BITS-1:0]    cost_value_i,
  input  wire  [ctci_pkg::IN_WORD_BITS-1:0]    query_level_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [ctci_pkg::OUT_INDEX_BITS-1:0]  covered_index_o,
  output logic                                 any_covered_o,
  output logic                                 table_empty_o
);
  import ctci_pkg::*;

  eng_req_t req;
  eng_res_t res;
  logic     slot_free;

  logic                      out_valid_q;
  logic [OUT_INDEX_BITS-1:0] index_q;
  logic                      covered_q;
  logic                      empty_q;

  assign req.valid = in_valid_i;
  assign req.cmd   = cmd_i;
  assign req.cost  = cost_value_i;
  assign req.level = query_level_i;

  ctci_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .ready_o     (in_ready_o),
    .res_o       (res),
    .res_ready_i (slot_free)
  );

  assign slot_free = !out_valid_q || out_ready_i;

  // Advance the output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res.valid;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (slot_free && res.valid) begin
      index_q   <= res.index;
      covered_q <= res.covered;
      empty_q   <= res.empty;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign covered_index_o = index_q;
  assign any_covered_o   = covered_q;
  assign table_empty_o   = empty_q;

endmodule

`default_nettype wire

FILE: rtl/core/ctci_checker.sv
// Port-level checker for the cost table coverage block, bound to the top level.
`default_nettype none

module ctci_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 in_valid_i,
  input wire                                 in_ready_o,
  input wire [ctci_pkg::CMD_BITS-1:0]        cmd_i,
  input wire                                 out_valid_o,
  input wire                                 out_ready_i,
  input wire [ctci_pkg::OUT_INDEX_BITS-1:0]  covered_index_o,
  input wire                                 any_covered_o,
  input wire                                 table_empty_o
);
  import ctci_pkg::*;

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(covered_index_o))
    else $error("stalled result dropped or changed");

  // An empty table never reports coverage
  a_empty_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_empty_o |-> !any_covered_o && (covered_index_o == '0))
    else $error("empty table reported coverage");

  // An uncovered result carries index zero
  a_uncovered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !any_covered_o |-> (covered_index_o == '0))
    else $error("uncovered result with nonzero index");

  // An accepted query takes the engine out of the idle state, so it is not ready after the handshake
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_QUERY) |=> !in_ready_o)
    else $error("query accepted without search cycle");

endmodule

bind cost_table_coverage_inverse ctci_checker u_ctci_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .cmd_i           (cmd_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .covered_index_o (covered_index_o),
  .any_covered_o   (any_covered_o),
  .table_empty_o   (table_empty_o)
);

`default_nettype wire
